### design/tte_pkg.sv
// Shared types, constants and score helpers for the transposition table engine.
// Used by the controller, the datapath, the top level and the checker.
package tte_pkg;

  // Table size; must be a power of two so the index is the low key bits.
  localparam int TABLE_ENTRIES = 4096;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);

  typedef enum logic [1:0] {
    OP_PROBE      = 2'd0,
    OP_STORE      = 2'd1,
    OP_NEW_SEARCH = 2'd2,
    OP_CLEAR      = 2'd3
  } op_t;

  localparam logic [1:0] BOUND_EXACT = 2'd3;

  localparam logic CFG_MATE_VALUE     = 1'b0;
  localparam logic CFG_MAX_SEARCH_PLY = 1'b1;

  localparam logic [14:0] MATE_VALUE_RST     = 15'd32000;
  localparam logic [9:0]  MAX_SEARCH_PLY_RST = 10'd128;

  typedef struct packed {
    logic               valid;
    logic [63:0]        tag;
    logic signed [15:0] score;
    logic [7:0]         depth;
    logic [15:0]        move;
    logic [1:0]         bound;
    logic [7:0]         age;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic eval;
    logic clr_start;
    logic clr_step;
    logic report;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic clr_last;
  } status_t;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // Converts a search score into table form: mate scores move away from zero by ply.
  function automatic logic signed [15:0] to_table(input logic signed [15:0] s,
                                                  input logic [9:0] p,
                                                  input logic signed [17:0] e);
    logic signed [17:0] sx;
    logic signed [17:0] px;
    logic signed [15:0] r;
    sx = $signed({{2{s[15]}}, s});
    px = $signed({8'b0, p});
    if (sx > e) begin
      r = sat16(sx + px);
    end else if (sx < -e) begin
      r = sat16(sx - px);
    end else begin
      r = s;
    end
    return r;
  endfunction

  // Converts a table score back to the caller's ply.
  function automatic logic signed [15:0] from_table(input logic signed [15:0] s,
                                                    input logic [9:0] p,
                                                    input logic signed [17:0] e);
    logic signed [17:0] sx;
    logic signed [17:0] px;
    logic signed [15:0] r;
    sx = $signed({{2{s[15]}}, s});
    px = $signed({8'b0, p});
    if (sx > e) begin
      r = sat16(sx - px);
    end else if (sx < -e) begin
      r = sat16(sx + px);
    end else begin
      r = s;
    end
    return r;
  endfunction

endpackage

### design/tte_ctrl.sv
// Controller state machine of the transposition table engine.
// Depends on tte_pkg for the command, status and operation types.
module tte_ctrl import tte_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_EVAL  = 3'b010,
    ST_CLEAR = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   clr_report;
  logic   clr_report_next;

  always_comb begin
    state_next      = state;
    clr_report_next = clr_report;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (status.op == OP_CLEAR) begin
          state_next      = ST_CLEAR;
          clr_report_next = 1'b1;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        if (status.clr_last) begin
          state_next      = ST_IDLE;
          clr_report_next = 1'b0;
        end
      end
      default: begin
        state_next      = ST_IDLE;
        clr_report_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      // The table is swept once after reset; that sweep reports nothing.
      state      <= ST_CLEAR;
      clr_report <= 1'b0;
    end else begin
      state      <= state_next;
      clr_report <= clr_report_next;
    end
  end

  always_comb begin
    cmd.capture   = (state == ST_IDLE) && start;
    cmd.eval      = (state == ST_EVAL);
    cmd.clr_start = (state == ST_EVAL) && (status.op == OP_CLEAR);
    cmd.clr_step  = (state == ST_CLEAR);
    cmd.report    = ((state == ST_EVAL) && (status.op != OP_CLEAR)) ||
                    ((state == ST_CLEAR) && status.clr_last && clr_report);
  end

  assign busy = (state != ST_IDLE);

endmodule

### design/tte_datapath.sv
// Datapath of the transposition table engine: table memory, search age,
// clear cursor, configuration registers and result registers. Uses tte_pkg.
module tte_datapath import tte_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic               cfg_we,
  input  logic               cfg_addr,
  input  logic [14:0]        cfg_wdata,
  input  logic [1:0]         operation,
  input  logic [63:0]        key,
  input  logic [7:0]         depth,
  input  logic signed [15:0] score,
  input  logic [15:0]        new_move,
  input  logic [1:0]         bound,
  input  logic [9:0]         ply,
  output logic               done,
  output logic               hit,
  output logic signed [15:0] raw_score,
  output logic signed [15:0] score_at_ply,
  output logic [7:0]         entry_depth,
  output logic [15:0]        entry_move,
  output logic [1:0]         entry_bound
);

  entry_t mem [TABLE_ENTRIES];
  entry_t rd_entry;

  logic [14:0] mate_value;
  logic [9:0]  max_search_ply;
  logic [7:0]  search_age;
  logic [IDX_W-1:0] clear_cursor;

  op_t                op_q;
  logic [63:0]        key_q;
  logic [7:0]         depth_q;
  logic signed [15:0] score_q;
  logic [15:0]        move_q;
  logic [1:0]         bound_q;
  logic [9:0]         ply_q;

  logic signed [17:0] mate_edge;
  logic signed [15:0] table_score;
  logic               match;
  logic               replace;
  entry_t             upd_entry;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      mate_value     <= MATE_VALUE_RST;
      max_search_ply <= MAX_SEARCH_PLY_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_MATE_VALUE:     mate_value     <= cfg_wdata;
        CFG_MAX_SEARCH_PLY: max_search_ply <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= op_t'(operation);
      key_q   <= key;
      depth_q <= depth;
      score_q <= score;
      move_q  <= new_move;
      bound_q <= bound;
      ply_q   <= ply;
    end
  end

  assign mate_edge   = $signed({3'b0, mate_value}) - $signed({8'b0, max_search_ply});
  assign table_score = to_table(score_q, ply_q, mate_edge);
  assign match       = rd_entry.valid && (rd_entry.tag == key_q);
  assign replace     = !rd_entry.valid || (rd_entry.age != search_age) ||
                       (depth_q >= rd_entry.depth);

  always_comb begin
    upd_entry = rd_entry;
    if (match) begin
      if (move_q != 16'd0) begin
        upd_entry.move = move_q;
      end
      if ((depth_q >= rd_entry.depth) || (bound_q == BOUND_EXACT)) begin
        upd_entry.score = table_score;
        upd_entry.depth = depth_q;
        upd_entry.bound = bound_q;
      end
      upd_entry.age = search_age;
    end else begin
      upd_entry.valid = 1'b1;
      upd_entry.tag   = key_q;
      upd_entry.score = table_score;
      upd_entry.depth = depth_q;
      upd_entry.move  = move_q;
      upd_entry.bound = bound_q;
      upd_entry.age   = search_age;
    end
  end

  always_comb begin
    wr_en   = cmd.clr_step ||
              (cmd.eval && (op_q == OP_STORE) && (match || replace));
    wr_addr = cmd.clr_step ? clear_cursor : key_q[IDX_W-1:0];
    wr_data = cmd.clr_step ? '0 : upd_entry;
  end

  // The read address comes straight from the key port so the entry is ready
  // in the cycle after the transaction is taken.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_entry <= mem[key[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      search_age   <= 8'd0;
      clear_cursor <= '0;
    end else begin
      if (cmd.clr_start) begin
        search_age   <= 8'd0;
        clear_cursor <= '0;
      end else if (cmd.clr_step) begin
        clear_cursor <= clear_cursor + 1'b1;
      end
      if (cmd.eval && (op_q == OP_NEW_SEARCH)) begin
        search_age <= (search_age == 8'hFF) ? 8'h01 : search_age + 8'd1;
      end
    end
  end

  assign status.op       = op_q;
  assign status.clr_last = (clear_cursor == IDX_W'(TABLE_ENTRIES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.report;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.report) begin
      if (cmd.eval && (op_q == OP_PROBE) && match) begin
        hit          <= 1'b1;
        raw_score    <= rd_entry.score;
        score_at_ply <= from_table(rd_entry.score, ply_q, mate_edge);
        entry_depth  <= rd_entry.depth;
        entry_move   <= rd_entry.move;
        entry_bound  <= rd_entry.bound;
      end else begin
        hit          <= 1'b0;
        raw_score    <= '0;
        score_at_ply <= '0;
        entry_depth  <= '0;
        entry_move   <= '0;
        entry_bound  <= '0;
      end
    end
  end

endmodule

### design/transposition_table_engine_unit.sv
// For probe, store and new-search operations, the cycle after start
// reads the table entry, and done with the result fields is registered
// from that cycle and shows while busy is already low again, so a new
// transaction can be taken in the cycle in which done is high. A store
// writes the table memory at most once per transaction. A clear writes
// every entry, one per cycle, and reports done once the last entry is
// written. After reset the block is busy while it empties the table and
// gives no result; configuration writes are taken at any time. Results
// cannot be stalled: done is high for exactly one cycle per transaction.
// Depends on tte_pkg, tte_ctrl and tte_datapath.
module transposition_table_engine_unit import tte_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_addr,
  input  logic [14:0]        cfg_wdata,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         operation,
  input  logic [63:0]        key,
  input  logic [7:0]         depth,
  input  logic signed [15:0] score,
  input  logic [15:0]        new_move,
  input  logic [1:0]         bound,
  input  logic [9:0]         ply,
  output logic               done,
  output logic               hit,
  output logic signed [15:0] raw_score,
  output logic signed [15:0] score_at_ply,
  output logic [7:0]         entry_depth,
  output logic [15:0]        entry_move,
  output logic [1:0]         entry_bound
);

  cmd_t    cmd;
  status_t status;

  tte_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  tte_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .operation    (operation),
    .key          (key),
    .depth        (depth),
    .score        (score),
    .new_move     (new_move),
    .bound        (bound),
    .ply          (ply),
    .done         (done),
    .hit          (hit),
    .raw_score    (raw_score),
    .score_at_ply (score_at_ply),
    .entry_depth  (entry_depth),
    .entry_move   (entry_move),
    .entry_bound  (entry_bound)
  );

endmodule

### design/tte_checker.sv
// Port-level checker for the transposition table engine, bound to the top level.
// Depends on tte_pkg for the operation codes.
module tte_checker import tte_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic [1:0]         operation,
  input logic               done,
  input logic               hit,
  input logic signed [15:0] raw_score,
  input logic [15:0]        entry_move
);

  // A result is only shown once the block is free for the next transaction.
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");

  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held longer than one cycle");

  // Every transaction but a clear completes: done follows its evaluation state.
  assert property (@(posedge clk) disable iff (rst)
      (start && !busy && (operation != OP_CLEAR)) |-> ##2 done)
    else $error("result missing two cycles after start");

  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("busy not raised after a transaction was taken");

  // A miss or a non-probe transaction returns all-zero fields.
  assert property (@(posedge clk) disable iff (rst)
      (done && !hit) |-> ((entry_move == 16'd0) && (raw_score == 16'sd0)))
    else $error("nonzero fields on a miss");

endmodule

bind transposition_table_engine_unit tte_checker u_tte_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .operation    (operation),
  .done         (done),
  .hit          (hit),
  .raw_score    (raw_score),
  .entry_move   (entry_move)
);

### verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for transposition_table_engine_unit: probe, store, new-search and
// clear transactions are checked against a behavioral table model kept here.
// Depends on tte_pkg and the transposition_table_engine_unit RTL.
module tb;
  import tte_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    op_t                op;
    logic [63:0]        key;
    logic [7:0]         depth;
    logic signed [15:0] score;
    logic [15:0]        move;
    logic [1:0]         bound;
    logic [9:0]         ply;
  } tt_cmd_t;

  typedef struct packed {
    logic               hit;
    logic signed [15:0] stored;
    logic signed [15:0] at_ply;
    logic [7:0]         depth;
    logic [15:0]        move;
    logic [1:0]         bound;
  } tt_reply_t;

  typedef struct packed {
    logic               valid;
    logic [63:0]        tag;
    logic signed [15:0] score;
    logic [7:0]         depth;
    logic [15:0]        move;
    logic [1:0]         bound;
    logic [7:0]         age;
  } tt_slot_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic               cfg_addr = 1'b0;
  logic [14:0]        cfg_wdata = '0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         operation = '0;
  logic [63:0]        key = '0;
  logic [7:0]         depth = '0;
  logic signed [15:0] score = '0;
  logic [15:0]        new_move = '0;
  logic [1:0]         bound = '0;
  logic [9:0]         ply = '0;
  logic               done;
  logic               hit;
  logic signed [15:0] raw_score;
  logic signed [15:0] score_at_ply;
  logic [7:0]         entry_depth;
  logic [15:0]        entry_move;
  logic [1:0]         entry_bound;

  transposition_table_engine_unit u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .start(start), .busy(busy),
    .operation(operation), .key(key), .depth(depth), .score(score),
    .new_move(new_move), .bound(bound), .ply(ply),
    .done(done), .hit(hit), .raw_score(raw_score), .score_at_ply(score_at_ply),
    .entry_depth(entry_depth), .entry_move(entry_move), .entry_bound(entry_bound)
  );

  // Table model and its configuration copy.
  tt_slot_t    tt_mem [TABLE_ENTRIES];
  logic [7:0]  search_age;
  logic [14:0] mate_cfg;
  logic [9:0]  band_cfg;

  tt_cmd_t     cmd_q[$];
  tt_reply_t   reply_q[$];
  tt_cmd_t     cur_cmd;
  logic [63:0] hot_keys [16];
  int          idle_left = 0;
  int          burst_left = 0;
  int          clears_left = 10;
  int          err_cnt = 0;
  int          cycle_cnt = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int clip16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Mate scores are pushed away from zero by ply on the way into the table.
  function automatic int score_into_table(int s, int p);
    int mate_edge;
    mate_edge = int'(mate_cfg) - int'(band_cfg);
    if (s > mate_edge) return clip16(s + p);
    if (s < -mate_edge) return clip16(s - p);
    return s;
  endfunction

  function automatic int score_out_of_table(int s, int p);
    int mate_edge;
    mate_edge = int'(mate_cfg) - int'(band_cfg);
    if (s > mate_edge) return clip16(s - p);
    if (s < -mate_edge) return clip16(s + p);
    return s;
  endfunction

  function automatic void wipe_table();
    for (int i = 0; i < TABLE_ENTRIES; i++) tt_mem[i] = '0;
    search_age = '0;
  endfunction

  function automatic tt_reply_t table_apply(tt_cmd_t c);
    tt_reply_t r;
    tt_slot_t  s;
    int        idx;
    logic      match;
    r = '0;
    idx = int'(c.key % 64'(TABLE_ENTRIES));
    s = tt_mem[idx];
    match = s.valid && (s.tag == c.key);
    case (c.op)
      OP_PROBE: begin
        if (match) begin
          r.hit    = 1'b1;
          r.stored = s.score;
          r.at_ply = 16'(score_out_of_table(int'(s.score), int'(c.ply)));
          r.depth  = s.depth;
          r.move   = s.move;
          r.bound  = s.bound;
        end
      end
      OP_STORE: begin
        if (match) begin
          if (c.move != 16'd0) s.move = c.move;
          if (c.depth >= s.depth || c.bound == BOUND_EXACT) begin
            s.score = 16'(score_into_table(int'(c.score), int'(c.ply)));
            s.depth = c.depth;
            s.bound = c.bound;
          end
          s.age = search_age;
        end else if (!s.valid || s.age != search_age || c.depth >= s.depth) begin
          s.valid = 1'b1;
          s.tag   = c.key;
          s.score = 16'(score_into_table(int'(c.score), int'(c.ply)));
          s.depth = c.depth;
          s.move  = c.move;
          s.bound = c.bound;
          s.age   = search_age;
        end
        tt_mem[idx] = s;
      end
      OP_NEW_SEARCH: begin
        // The age never returns to zero, which is reserved for a freshly cleared table.
        search_age = (search_age == 8'd255) ? 8'd1 : search_age + 8'd1;
      end
      default: wipe_table();
    endcase
    return r;
  endfunction

  function automatic tt_cmd_t mk(op_t o, logic [63:0] k, int d, int s, int m, int b, int p);
    tt_cmd_t c;
    c.op    = o;
    c.key   = k;
    c.depth = 8'(d);
    c.score = 16'(s);
    c.move  = 16'(m);
    c.bound = 2'(b);
    c.ply   = 10'(p);
    return c;
  endfunction

  function automatic logic [63:0] pick_key();
    int sel;
    logic [63:0] k;
    sel = $urandom_range(0, 19);
    k = hot_keys[$urandom_range(0, 15)];
    if (sel >= 17) begin
      k = {$urandom, $urandom};
    end else if (sel >= 15) begin
      // Same table slot as a hot key but a tag nobody stored.
      k = {$urandom, $urandom};
      k[IDX_W-1:0] = hot_keys[$urandom_range(0, 15)][IDX_W-1:0];
    end
    return k;
  endfunction

  function automatic int pick_score();
    int sel;
    int v;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2, 3: v = int'($urandom_range(0, 65535)) - 32768;
      4, 5, 6:    v = int'(mate_cfg) - int'($urandom_range(0, int'(band_cfg) + 3));
      7:          v = int'(mate_cfg) - int'(band_cfg) + int'($urandom_range(0, 2)) - 1;
      8:          v = $urandom_range(0, 1) ? 32767 : -32768;
      default:    v = int'($urandom_range(0, 40)) - 20;
    endcase
    if (sel >= 4 && sel <= 7 && $urandom_range(0, 1) == 1) v = -v;
    return clip16(v);
  endfunction

  function automatic tt_cmd_t random_cmd();
    int   sel;
    op_t  o;
    sel = $urandom_range(0, 99);
    if (sel < 45) o = OP_PROBE;
    else if (sel < 90) o = OP_STORE;
    else if (sel < 99) o = OP_NEW_SEARCH;
    else if (clears_left > 0) begin
      o = OP_CLEAR;
      clears_left--;
    end else o = OP_PROBE;
    return mk(o, pick_key(),
              $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 255),
              pick_score(),
              ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 65535),
              $urandom_range(0, 3),
              $urandom_range(0, 1) ? $urandom_range(0, 20) : $urandom_range(0, 1023));
  endfunction

  function automatic int draw_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      burst_left = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  // Driver: holds start until the transaction is taken, then idles a drawn number of cycles.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        reply_q.push_back(table_apply(cur_cmd));
        idle_left = draw_gap();
      end
      if (!start || !busy) begin
        if (idle_left > 0 || cmd_q.size() == 0) begin
          if (idle_left > 0) idle_left--;
          start <= 1'b0;
        end else begin
          cur_cmd = cmd_q.pop_front();
          operation <= cur_cmd.op;
          key       <= cur_cmd.key;
          depth     <= cur_cmd.depth;
          score     <= cur_cmd.score;
          new_move  <= cur_cmd.move;
          bound     <= cur_cmd.bound;
          ply       <= cur_cmd.ply;
          start     <= 1'b1;
        end
      end
    end
  end

  function automatic void check_field(string what, logic [15:0] want_v, logic [15:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s expected %h actual %h", $time, what, want_v, got_v);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    tt_reply_t want;
    if (!rst && done) begin
      if (reply_q.size() == 0) begin
        $display("%0t: result with no transaction pending", $time);
        err_cnt++;
      end else begin
        want = reply_q.pop_front();
        check_field("hit", 16'(want.hit), 16'(hit));
        check_field("raw_score", want.stored, raw_score);
        check_field("score_at_ply", want.at_ply, score_at_ply);
        check_field("entry_depth", 16'(want.depth), 16'(entry_depth));
        check_field("entry_move", want.move, entry_move);
        check_field("entry_bound", 16'(want.bound), 16'(entry_bound));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Sampled on the falling edge so that all rising-edge activity has settled.
  task automatic wait_quiet();
    do @(negedge clk);
    while (cmd_q.size() != 0 || start || reply_q.size() != 0);
  endtask

  task automatic write_reg(logic addr, logic [14:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (addr == CFG_MATE_VALUE) mate_cfg = data;
    else band_cfg = data[9:0];
  endtask

  task automatic set_scoring(int mate, int band);
    write_reg(CFG_MATE_VALUE, 15'(mate));
    // Upper bits above the ply band register carry junk that must be dropped.
    write_reg(CFG_MAX_SEARCH_PLY, {5'($urandom), 10'(band)});
  endtask

  task automatic run_phase(int mate, int band, int n);
    wait_quiet();
    set_scoring(mate, band);
    for (int i = 0; i < n; i++) cmd_q.push_back(random_cmd());
    wait_quiet();
  endtask

  initial begin
    logic [63:0] k1;
    logic [63:0] k2;
    logic [63:0] k3;
    wipe_table();
    mate_cfg = MATE_VALUE_RST;
    band_cfg = MAX_SEARCH_PLY_RST;
    // A few table slots each shared by two or three tags, so that hits and evictions are common.
    for (int i = 0; i < 16; i++) begin
      hot_keys[i] = {$urandom, $urandom};
      if (i >= 6) hot_keys[i][IDX_W-1:0] = hot_keys[i % 6][IDX_W-1:0];
    end
    k1 = hot_keys[0];
    k2 = hot_keys[0] ^ (64'd1 << IDX_W);
    k3 = hot_keys[1];

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    set_scoring(32000, 128);
    cmd_q.push_back(mk(OP_PROBE, 64'd0, 0, 0, 0, 0, 0));
    cmd_q.push_back(mk(OP_STORE, k1, 10, 100, 16'h1234, 1, 5));
    cmd_q.push_back(mk(OP_PROBE, k1, 0, 0, 0, 0, 7));
    cmd_q.push_back(mk(OP_STORE, k1, 5, 200, 0, 2, 5));
    cmd_q.push_back(mk(OP_PROBE, k1, 0, 0, 0, 0, 0));
    cmd_q.push_back(mk(OP_STORE, k1, 3, 32767, 16'hFFFF, BOUND_EXACT, 1023));
    cmd_q.push_back(mk(OP_PROBE, k1, 0, 0, 0, 0, 1023));
    cmd_q.push_back(mk(OP_STORE, k2, 2, 5, 7, 1, 0));
    cmd_q.push_back(mk(OP_PROBE, k2, 0, 0, 0, 0, 0));
    cmd_q.push_back(mk(OP_NEW_SEARCH, 64'd0, 0, 0, 0, 0, 0));
    cmd_q.push_back(mk(OP_STORE, k2, 0, -5, 9, 2, 0));
    cmd_q.push_back(mk(OP_PROBE, k2, 0, 0, 0, 0, 3));
    cmd_q.push_back(mk(OP_STORE, '1, 255, -32768, 16'hFFFF, 0, 1023));
    cmd_q.push_back(mk(OP_PROBE, '1, 255, -1, 16'hFFFF, 3, 1023));
    cmd_q.push_back(mk(OP_STORE, 64'd0, 1, 0, 0, BOUND_EXACT, 0));
    cmd_q.push_back(mk(OP_PROBE, 64'd0, 0, 0, 0, 0, 0));
    cmd_q.push_back(mk(OP_STORE, k3, 7, -31900, 42, BOUND_EXACT, 300));
    cmd_q.push_back(mk(OP_PROBE, k3, 0, 0, 0, 0, 0));
    cmd_q.push_back(mk(OP_PROBE, k3, 0, 0, 0, 0, 300));
    cmd_q.push_back(mk(OP_CLEAR, 64'd0, 0, 0, 0, 0, 0));
    cmd_q.push_back(mk(OP_PROBE, k2, 0, 0, 0, 0, 0));
    cmd_q.push_back(mk(OP_PROBE, k3, 0, 0, 0, 0, 0));
    // Just above and exactly at the mate boundary.
    cmd_q.push_back(mk(OP_STORE, k1, 0, 31873, 1, 1, 10));
    cmd_q.push_back(mk(OP_PROBE, k1, 0, 0, 0, 0, 1023));
    cmd_q.push_back(mk(OP_STORE, k1, 0, 31872, 0, 0, 10));
    cmd_q.push_back(mk(OP_PROBE, k1, 0, 0, 0, 0, 10));
    wait_quiet();

    // After 255 new searches the age is back where it was, so a shallower store must not evict.
    cmd_q.push_back(mk(OP_NEW_SEARCH, 64'd0, 0, 0, 0, 0, 0));
    cmd_q.push_back(mk(OP_STORE, k1, 200, 77, 5, 1, 0));
    for (int i = 0; i < 255; i++) cmd_q.push_back(mk(OP_NEW_SEARCH, 64'd0, 0, 0, 0, 0, 0));
    cmd_q.push_back(mk(OP_STORE, k2, 10, 88, 6, 1, 0));
    cmd_q.push_back(mk(OP_PROBE, k1, 0, 0, 0, 0, 0));
    cmd_q.push_back(mk(OP_PROBE, k2, 0, 0, 0, 0, 0));
    cmd_q.push_back(mk(OP_NEW_SEARCH, 64'd0, 0, 0, 0, 0, 0));
    cmd_q.push_back(mk(OP_STORE, k2, 10, 88, 6, 1, 0));
    cmd_q.push_back(mk(OP_PROBE, k2, 0, 0, 0, 0, 0));
    wait_quiet();

    run_phase(32767, 1023, 50);
    run_phase(0, 1, 50);
    run_phase(0, 1023, 50);
    run_phase(32767, 1, 50);
    run_phase(1200, 700, 50);
    run_phase($urandom_range(0, 32767), $urandom_range(1, 1023), 50);

    wait_quiet();
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
design/tte_pkg.sv
design/tte_ctrl.sv
design/tte_datapath.sv
design/transposition_table_engine_unit.sv
design/tte_checker.sv
verif/tb.sv
